// ----- rtl/swerve_inverse_kinematics_defines.svh -----
// Assertion macros for the swerve inverse kinematics block.
`ifndef SWERVE_INVERSE_KINEMATICS_DEFINES_SVH
`define SWERVE_INVERSE_KINEMATICS_DEFINES_SVH

// same-cycle implication
`define SWIK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWIK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/swik_pkg.sv -----
package swik_pkg;

	localparam int NUM_WHEELS   = 4;
	localparam int CORDIC_STEPS = 24;
	localparam int SQRT_STEPS   = 16;

	localparam logic [2:0] REG_HALF_LENGTH = 3'd0;
	localparam logic [2:0] REG_HALF_WIDTH  = 3'd1;
	localparam logic [2:0] REG_LAT_OFF_W0  = 3'd2;
	localparam logic [2:0] REG_LAT_OFF_W1  = 3'd3;
	localparam logic [2:0] REG_LAT_OFF_W2  = 3'd4;
	localparam logic [2:0] REG_LAT_OFF_W3  = 3'd5;

	localparam logic [14:0] HALF_LENGTH_RST = 15'd4096;
	localparam logic [14:0] HALF_WIDTH_RST  = 15'd4096;

	localparam logic [1:0] LAST_WHEEL = 2'd3;
	// bit i set: king-pin coordinate of wheel i is negative
	localparam logic [3:0] WHEEL_X_NEG = 4'b0110;
	localparam logic [3:0] WHEEL_Y_NEG = 4'b1100;

	localparam logic signed [27:0] HALF_PI_Z = 28'sd26353589;
	localparam logic signed [16:0] ANG_MAX   = 17'sd25736;

	// atan(2^-i) in 2^-24 rad
	localparam logic signed [27:0] ATAN_TAB [CORDIC_STEPS] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
		28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
		28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
		28'sd256,      28'sd128,     28'sd64,      28'sd32,
		28'sd16,       28'sd8,       28'sd4,       28'sd2
	};

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [27:0] z;
		logic        [31:0] n;
		logic        [31:0] r;
		logic               zero;
		logic signed [15:0] off;
		logic        [1:0]  wheel;
	} cell_data_t;

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		if (v > 21'sd32767) begin
			return 16'sh7fff;
		end else if (v < -21'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

endpackage

// ----- rtl/swik_front.sv -----
module swik_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [1:0]                wheel,
	input  logic signed [15:0]        vel_x,
	input  logic signed [15:0]        vel_y,
	input  logic signed [15:0]        yaw,
	input  logic [14:0]               half_len,
	input  logic [14:0]               half_wid,
	input  logic signed [15:0]        lat_off,
	output logic                      out_valid,
	output swik_pkg::cell_data_t      out_data
);

	// stage 1: products
	logic signed [16:0] yaw_ext, yaw_x, yaw_y;
	logic signed [33:0] prod_x, prod_y;
	logic signed [31:0] prod_h;

	logic               v_s1;
	logic signed [31:0] px_s1, py_s1, ph_s1;
	logic signed [15:0] vx_s1, vy_s1;
	logic [1:0]         wheel_s1;

	always_comb begin
		yaw_ext = 17'(yaw);
		yaw_x   = swik_pkg::WHEEL_X_NEG[wheel] ? -yaw_ext : yaw_ext;
		yaw_y   = swik_pkg::WHEEL_Y_NEG[wheel] ? -yaw_ext : yaw_ext;
		prod_x  = yaw_x * $signed({2'b00, half_len});
		prod_y  = yaw_y * $signed({2'b00, half_wid});
		prod_h  = yaw * lat_off;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= prod_x[31:0];
			py_s1    <= prod_y[31:0];
			ph_s1    <= prod_h;
			vx_s1    <= vel_x;
			vy_s1    <= vel_y;
			wheel_s1 <= wheel;
		end
	end

	// stage 2: round half up, wheel velocity, saturate
	logic signed [31:0] tx, ty, th;

	logic               v_s2;
	logic signed [15:0] wx_s2, wy_s2, off_s2;
	logic [1:0]         wheel_s2;

	always_comb begin
		tx = (px_s1 + 32'sd4096) >>> 13;
		ty = (py_s1 + 32'sd4096) >>> 13;
		th = (ph_s1 + 32'sd16384) >>> 15;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s2    <= swik_pkg::sat16(21'(vx_s1) - 21'(ty));
			wy_s2    <= swik_pkg::sat16(21'(vy_s1) + 21'(tx));
			off_s2   <= swik_pkg::sat16(21'(th));
			wheel_s2 <= wheel_s1;
		end
	end

	// stage 3: squares
	logic signed [31:0] sq_x, sq_y;

	logic               v_s3;
	logic [31:0]        sqx_s3, sqy_s3;
	logic signed [15:0] wx_s3, wy_s3, off_s3;
	logic [1:0]         wheel_s3;

	always_comb begin
		sq_x = wx_s2 * wx_s2;
		sq_y = wy_s2 * wy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3   <= sq_x;
			sqy_s3   <= sq_y;
			wx_s3    <= wx_s2;
			wy_s3    <= wy_s2;
			off_s3   <= off_s2;
			wheel_s3 <= wheel_s2;
		end
	end

	// stage 4: sum of squares, CORDIC pre-rotation into the right half-plane
	logic signed [32:0]   xs, ys;
	swik_pkg::cell_data_t init;

	logic                 v_s4;
	swik_pkg::cell_data_t d_s4;

	always_comb begin
		xs = 33'(wx_s3) <<< 14;
		ys = 33'(wy_s3) <<< 14;
		init.x     = xs;
		init.y     = ys;
		init.z     = '0;
		init.n     = sqx_s3 + sqy_s3;
		init.r     = '0;
		init.zero  = (wx_s3 == 16'sd0) && (wy_s3 == 16'sd0);
		init.off   = off_s3;
		init.wheel = wheel_s3;
		if (wx_s3 < 16'sd0) begin
			if (wy_s3 >= 16'sd0) begin
				init.x = ys;
				init.y = -xs;
				init.z = swik_pkg::HALF_PI_Z;
			end else begin
				init.x = -ys;
				init.y = xs;
				init.z = -swik_pkg::HALF_PI_Z;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4 <= init;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = d_s4;

endmodule

// ----- rtl/swik_cell.sv -----
module swik_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  swik_pkg::cell_data_t in_data,
	output logic                 out_valid,
	output swik_pkg::cell_data_t out_data
);

	localparam logic signed [27:0] ATAN_Z  = swik_pkg::ATAN_TAB[STEP];
	localparam bit                 SQRT_ON = (STEP < swik_pkg::SQRT_STEPS);
	localparam int                 BIT_POS = SQRT_ON ? (30 - 2 * STEP) : 0;
	localparam logic [31:0]        SQ_BIT  = 32'd1 << BIT_POS;

	logic signed [32:0]   dx, dy;
	logic [31:0]          trial;
	swik_pkg::cell_data_t nxt;

	logic                 valid_q;
	swik_pkg::cell_data_t data_q;

	always_comb begin
		nxt   = in_data;
		dx    = in_data.y >>> STEP;
		dy    = in_data.x >>> STEP;
		trial = in_data.r + SQ_BIT;
		// one CORDIC vectoring step, drive y toward zero
		if (!in_data.y[32]) begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + ATAN_Z;
		end else begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - ATAN_Z;
		end
		// one restoring square-root digit
		if (SQRT_ON) begin
			if (in_data.n >= trial) begin
				nxt.n = in_data.n - trial;
				nxt.r = (in_data.r >> 1) + SQ_BIT;
			end else begin
				nxt.r = in_data.r >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- rtl/swerve_inverse_kinematics.sv -----
// Four-wheel swerve drive inverse kinematics.
// Input stream s_axis_*: one body twist per item (vx, vy Q4.12, yaw rate Q5.11).
// Output stream m_axis_*: one item per input item with steering angle, speed
// and contact-offset speed for all four wheels.
// Config channel cfg_*: index 0 half_length, 1 half_width, 2..5 lateral
// offsets of wheels 0..3; writes to other indexes are dropped. cfg_ready is
// always high; write only while no item is in flight.
// The four wheels share one datapath and enter it one per cycle while the
// pipeline is not held; the next item is taken in the cycle its predecessor's
// last wheel issues.
// Path from input acceptance to m_axis_tvalid: 4 product, rounding, square
// and pre-rotation stages, a row of 24 CORDIC / square-root cells, then the
// output register.
// Reset clears all valid state and loads half_length = half_width = 4096 and
// zero lateral offsets.
// While m_axis_tready is low and a finished item waits, all stages hold once
// the next item's last wheel is at the end; s_axis_tready drops while busy.
`include "swerve_inverse_kinematics_defines.svh"

module swerve_inverse_kinematics (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,   // body_vel_x, body_vel_y, yaw_rate
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// steer_w0..w3, speed_w0..w3, contact_speed_w0..w3
	output logic [191:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int NCELL = swik_pkg::CORDIC_STEPS;

	// configuration
	logic [14:0]        half_length_q, half_width_q;
	logic signed [15:0] lat_off_q [swik_pkg::NUM_WHEELS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_length_q <= swik_pkg::HALF_LENGTH_RST;
			half_width_q  <= swik_pkg::HALF_WIDTH_RST;
			for (int i = 0; i < swik_pkg::NUM_WHEELS; i++) begin
				lat_off_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				swik_pkg::REG_HALF_LENGTH: half_length_q <= cfg_data[14:0];
				swik_pkg::REG_HALF_WIDTH:  half_width_q  <= cfg_data[14:0];
				swik_pkg::REG_LAT_OFF_W0:  lat_off_q[0]  <= cfg_data;
				swik_pkg::REG_LAT_OFF_W1:  lat_off_q[1]  <= cfg_data;
				swik_pkg::REG_LAT_OFF_W2:  lat_off_q[2]  <= cfg_data;
				swik_pkg::REG_LAT_OFF_W3:  lat_off_q[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// chain
	logic                 chain_v [NCELL + 1];
	swik_pkg::cell_data_t chain_d [NCELL + 1];
	logic                 adv;
	logic                 tail_last;

	// issue: hold one item, send its four wheels on consecutive cycles unless held
	logic               busy_q;
	logic [1:0]         idx_q;
	logic signed [15:0] vx_q, vy_q, om_q;
	logic               accept;

	assign tail_last     = chain_v[NCELL] && (chain_d[NCELL].wheel == swik_pkg::LAST_WHEEL);
	assign adv           = !(tail_last && m_axis_tvalid && !m_axis_tready);
	assign s_axis_tready = !busy_q || (adv && idx_q == swik_pkg::LAST_WHEEL);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && adv) begin
			if (idx_q == swik_pkg::LAST_WHEEL) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= s_axis_tdata[15:0];
			vy_q <= s_axis_tdata[31:16];
			om_q <= s_axis_tdata[47:32];
		end
	end

	swik_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (busy_q),
		.wheel     (idx_q),
		.vel_x     (vx_q),
		.vel_y     (vy_q),
		.yaw       (om_q),
		.half_len  (half_length_q),
		.half_wid  (half_width_q),
		.lat_off   (lat_off_q[idx_q]),
		.out_valid (chain_v[0]),
		.out_data  (chain_d[0])
	);

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		swik_cell #(.STEP(g)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (chain_v[g]),
			.in_data   (chain_d[g]),
			.out_valid (chain_v[g + 1]),
			.out_data  (chain_d[g + 1])
		);
	end

	// finish: angle rounding and clamp, speed rounding
	logic signed [27:0] z_rnd;
	logic signed [16:0] ang;
	logic [15:0]        steer_fin, speed_fin;

	always_comb begin
		z_rnd = (chain_d[NCELL].z + 28'sd1024) >>> 11;
		ang   = 17'(z_rnd);
		if (ang > swik_pkg::ANG_MAX) begin
			ang = swik_pkg::ANG_MAX;
		end else if (ang < -swik_pkg::ANG_MAX) begin
			ang = -swik_pkg::ANG_MAX;
		end
		steer_fin = chain_d[NCELL].zero ? 16'd0 : ang[15:0];
		speed_fin = chain_d[NCELL].r[15:0] + 16'(chain_d[NCELL].n > chain_d[NCELL].r);
	end

	// collect wheels 0..2, then move the whole item to the output register
	logic [2:0][15:0] asm_steer_q, asm_speed_q, asm_off_q;
	logic             out_valid_q;
	logic [191:0]     out_data_q;

	always_ff @(posedge clk) begin
		if (adv && chain_v[NCELL] && !tail_last) begin
			asm_steer_q[chain_d[NCELL].wheel] <= steer_fin;
			asm_speed_q[chain_d[NCELL].wheel] <= speed_fin;
			asm_off_q[chain_d[NCELL].wheel]   <= chain_d[NCELL].off;
		end
		if (adv && tail_last) begin
			out_data_q <= {chain_d[NCELL].off, asm_off_q,
				speed_fin, asm_speed_q, steer_fin, asm_steer_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && tail_last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`SWIK_ASSERT_NOW(a_ready_busy, busy_q && s_axis_tready, adv && idx_q == swik_pkg::LAST_WHEEL, "ready while wheels remain")
	`SWIK_ASSERT_NEXT(a_accept_start, accept, busy_q && idx_q == 2'd0, "accepted item not issuing")
	`SWIK_ASSERT_NEXT(a_tail_out, adv && tail_last, out_valid_q, "finished item not presented")

endmodule

// ----- sim/swik_tb_pkg.sv -----
package swik_tb_pkg;

	typedef struct packed {
		logic signed [15:0] yaw_rate;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_x;
	} twist_t;

	// lowest bits first: steer w0..w3, speed w0..w3, contact speed w0..w3
	typedef struct packed {
		logic [3:0][15:0] contact_speed;
		logic [3:0][15:0] speed;
		logic [3:0][15:0] steer;
	} wheel_cmds_t;

	localparam longint QUARTER_TURN = 26353589;
	localparam longint ANGLE_LIMIT  = 25736;
	localparam int     ROTATIONS    = 24;

	// atan(2^-i), 2^-24 rad
	localparam longint ANGLE_STEP [ROTATIONS] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	class swerve_checker;
		logic [14:0]        half_length;
		logic [14:0]        half_width;
		logic signed [15:0] lat_offset [4];
		wheel_cmds_t        pending_cmds [$];
		int                 mismatches;
		int                 twists_seen;
		int                 results_checked;
		int                 standstill_wheels;
		int                 reverse_wheels;

		function new();
			half_length = swik_pkg::HALF_LENGTH_RST;
			half_width  = swik_pkg::HALF_WIDTH_RST;
			foreach (lat_offset[i]) lat_offset[i] = '0;
		endfunction

		function int pending();
			return pending_cmds.size();
		endfunction

		function longint clamp16(longint v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function longint round_half_up(longint p, int s);
			return (p + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function void apply_register(logic [2:0] idx, logic [15:0] data);
			case (idx)
				swik_pkg::REG_HALF_LENGTH: half_length = data[14:0];
				swik_pkg::REG_HALF_WIDTH:  half_width  = data[14:0];
				swik_pkg::REG_LAT_OFF_W0:  lat_offset[0] = data;
				swik_pkg::REG_LAT_OFF_W1:  lat_offset[1] = data;
				swik_pkg::REG_LAT_OFF_W2:  lat_offset[2] = data;
				swik_pkg::REG_LAT_OFF_W3:  lat_offset[3] = data;
				default: ;
			endcase
		endfunction

		function wheel_cmds_t wheel_commands(twist_t tw);
			wheel_cmds_t cmd;
			longint vx, vy, om, a, b, px, py, wx, wy;
			longint x, y, z, t, dx, dy, q, sq, r, off;
			vx = tw.vel_x;
			vy = tw.vel_y;
			om = tw.yaw_rate;
			a  = longint'(half_length);
			b  = longint'(half_width);
			for (int w = 0; w < 4; w++) begin
				px = (w == 1 || w == 2) ? -a : a;
				py = (w >= 2) ? -b : b;
				wx = clamp16(vx - round_half_up(py * om, 13));
				wy = clamp16(vy + round_half_up(px * om, 13));
				// heading by CORDIC vectoring, left half-plane pre-rotated
				if (wx == 0 && wy == 0) begin
					q = 0;
					standstill_wheels++;
				end else begin
					x = wx * 16384;
					y = wy * 16384;
					z = 0;
					if (x < 0) begin
						t = x;
						if (y >= 0) begin
							x = y;
							y = -t;
							z = QUARTER_TURN;
						end else begin
							x = -y;
							y = t;
							z = -QUARTER_TURN;
						end
					end
					for (int i = 0; i < ROTATIONS; i++) begin
						dx = y >>> i;
						dy = x >>> i;
						if (y >= 0) begin
							x = x + dx;
							y = y - dy;
							z = z + ANGLE_STEP[i];
						end else begin
							x = x - dx;
							y = y + dy;
							z = z - ANGLE_STEP[i];
						end
					end
					q = (z + 1024) >>> 11;
					if (q > ANGLE_LIMIT) q = ANGLE_LIMIT;
					if (q < -ANGLE_LIMIT) q = -ANGLE_LIMIT;
				end
				if (q == ANGLE_LIMIT) reverse_wheels++;
				// rounded magnitude
				sq = wx * wx + wy * wy;
				r = 0;
				for (int k = 15; k >= 0; k--) begin
					t = r + (longint'(1) << k);
					if (t * t <= sq) r = t;
				end
				if (sq - r * r > r) r++;
				off = clamp16(round_half_up(om * lat_offset[w], 15));
				cmd.steer[w]         = q[15:0];
				cmd.speed[w]         = r[15:0];
				cmd.contact_speed[w] = off[15:0];
			end
			return cmd;
		endfunction

		function void note_twist(logic [47:0] data);
			twist_t tw;
			tw = data;
			pending_cmds.push_back(wheel_commands(tw));
			twists_seen++;
		endfunction

		function void check_result(logic [191:0] data);
			wheel_cmds_t got, want;
			got = data;
			if (pending_cmds.size() == 0) begin
				mismatches++;
				$display("%0t: result with no twist pending: %h", $time, data);
				return;
			end
			want = pending_cmds.pop_front();
			results_checked++;
			for (int w = 0; w < 4; w++) begin
				if (got.steer[w] !== want.steer[w]) begin
					mismatches++;
					$display("%0t: steer_w%0d expected %0d actual %0d", $time, w,
						$signed(want.steer[w]), $signed(got.steer[w]));
				end
				if (got.speed[w] !== want.speed[w]) begin
					mismatches++;
					$display("%0t: speed_w%0d expected %0d actual %0d", $time, w,
						want.speed[w], got.speed[w]);
				end
				if (got.contact_speed[w] !== want.contact_speed[w]) begin
					mismatches++;
					$display("%0t: contact_speed_w%0d expected %0d actual %0d", $time, w,
						$signed(want.contact_speed[w]), $signed(got.contact_speed[w]));
				end
			end
		endfunction
	endclass

endpackage

// ----- sim/tb_swerve_inverse_kinematics.sv -----
module tb_swerve_inverse_kinematics;

	localparam int            RANDOM_PER_PHASE = 88;
	localparam int            LONG_HOLD        = 400;
	localparam int            WATCHDOG_LIMIT   = 4000;
	localparam int            SETTLE_CYCLES    = 40;
	localparam logic [2:0]    REG_SPARE_6      = 3'd6;
	localparam logic [2:0]    REG_SPARE_7      = 3'd7;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata;   // body_vel_x, body_vel_y, yaw_rate
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// steer_w0..w3, speed_w0..w3, contact_speed_w0..w3
	logic [191:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [15:0]  cfg_data;

	swik_tb_pkg::swerve_checker sb;
	bit            no_idle;
	bit            long_hold_req;
	int            idle_cycles;
	int            settings;

	swerve_inverse_kinematics DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) sb.note_twist(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			if (cfg_valid && cfg_ready) sb.apply_register(cfg_index, cfg_data);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
				$display("swerve_inverse_kinematics regression: fail");
				$finish;
			end
		end
	end

	// result side
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 6);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_twist(logic [15:0] vx, logic [15:0] vy, logic [15:0] om);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {om, vy, vx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_geometry(int a, int b, int h0, int h1, int h2, int h3);
		logic [15:0] hl, hw;
		hl     = 16'(a);
		hl[15] = 1'($urandom_range(0, 1));
		hw     = 16'(b);
		hw[15] = 1'($urandom_range(0, 1));
		write_register(swik_pkg::REG_HALF_LENGTH, hl);
		write_register(swik_pkg::REG_HALF_WIDTH, hw);
		write_register(swik_pkg::REG_LAT_OFF_W0, 16'(h0));
		write_register(swik_pkg::REG_LAT_OFF_W1, 16'(h1));
		write_register(swik_pkg::REG_LAT_OFF_W2, 16'(h2));
		write_register(swik_pkg::REG_LAT_OFF_W3, 16'(h3));
		// unmapped indexes must be dropped
		write_register(REG_SPARE_6, 16'($urandom));
		write_register(REG_SPARE_7, 16'($urandom));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	function automatic logic [15:0] pick_edge();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'hffff;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'h7fff;
		endcase
	endfunction

	function automatic swik_tb_pkg::twist_t random_twist();
		swik_tb_pkg::twist_t tw;
		int mode;
		mode = $urandom_range(0, 9);
		tw.vel_x    = 16'($urandom);
		tw.vel_y    = 16'($urandom);
		tw.yaw_rate = 16'($urandom);
		case (mode)
			5, 6: begin
				tw.vel_x    = 16'($urandom_range(0, 512) - 256);
				tw.vel_y    = 16'($urandom_range(0, 512) - 256);
				tw.yaw_rate = 16'($urandom_range(0, 512) - 256);
			end
			7: begin
				tw.vel_x    = pick_edge();
				tw.vel_y    = pick_edge();
				tw.yaw_rate = pick_edge();
			end
			8: tw.yaw_rate = '0;
			9: begin
				tw.vel_x = '0;
				tw.vel_y = '0;
			end
			default: ;
		endcase
		return tw;
	endfunction

	task automatic run_random(int count);
		swik_tb_pkg::twist_t tw;
		for (int n = 0; n < count; n++) begin
			tw = random_twist();
			send_twist(tw.vel_x, tw.vel_y, tw.yaw_rate);
		end
	endtask

	task automatic finish_phase();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int directed [18][3];
		int geom [4][6];
		directed = '{
			'{0, 0, 0}, '{-32768, 0, 0}, '{-1, 0, 0}, '{32767, 0, 0},
			'{0, 32767, 0}, '{0, -32768, 0}, '{-32768, -1, 0}, '{-32768, 32767, 0},
			'{32767, -32768, 0}, '{-32768, -32768, 0}, '{0, 0, 32767}, '{0, 0, -32768},
			'{32767, 32767, 32767}, '{-32768, -32768, -32768}, '{1, -1, 1},
			'{-1, -1, -1}, '{4096, 0, 2048}, '{0, 4096, -2048}
		};
		geom = '{
			'{32767, 32767, 32767, -32768, 1, -1},
			'{0, 0, 0, 0, 0, 0},
			'{1, 1, -32768, 32767, -1, 0},
			'{0, 32767, 100, -100, 32767, -32768}
		};
		sb            = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		no_idle       = 1'b0;
		long_hold_req = 1'b0;
		idle_cycles   = 0;
		settings      = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry first
		for (int k = 0; k < 18; k++) begin
			send_twist(16'(directed[k][0]), 16'(directed[k][1]), 16'(directed[k][2]));
		end
		run_random(RANDOM_PER_PHASE);
		finish_phase();

		for (int p = 0; p < 8; p++) begin
			if (p < 4) begin
				set_geometry(geom[p][0], geom[p][1], geom[p][2], geom[p][3],
					geom[p][4], geom[p][5]);
			end else begin
				set_geometry($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom, $urandom, $urandom, $urandom);
			end
			no_idle       = (p == 1 || p == 5);
			long_hold_req = (p == 3);
			run_random(RANDOM_PER_PHASE);
			finish_phase();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d twists sent, %0d wheel command sets checked, %0d geometry settings",
			sb.twists_seen, sb.results_checked, settings);
		$display("%0d standstill wheels, %0d wheels at +pi, one %0d-cycle output stall",
			sb.standstill_wheels, sb.reverse_wheels, LONG_HOLD);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("swerve_inverse_kinematics regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
			$display("swerve_inverse_kinematics regression: fail");
		end
		$finish;
	end

endmodule
